### hdl/jseu_pkg.sv
`default_nettype none

package jseu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWA   = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [7:0] C0_BS  = 8'h08;
    localparam logic [7:0] C0_TAB = 8'h09;
    localparam logic [7:0] C0_LF  = 8'h0A;
    localparam logic [7:0] C0_FF  = 8'h0C;
    localparam logic [7:0] C0_CR  = 8'h0D;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] E0_LO      = 8'hA0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] ED_HI      = 8'h9F;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] F4_HI      = 8'h8F;

    localparam logic [2:0] SEQ_END = 3'd5;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_REPL,
        CS_RAW,
        CS_FRESH
    } ctl_state_t;

    typedef enum logic [1:0] {
        SEG_REPL,
        SEG_RAW,
        SEG_FRESH
    } seg_t;

    typedef enum logic [2:0] {
        FR_NONE,
        FR_LIT,
        FR_ESC,
        FR_HEX,
        FR_REPL
    } fresh_t;

    typedef struct packed {
        logic load;
        logic step;
        seg_t seg;
        logic final_seg;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic seg_end;
        logic rep_more;
        logic raw_any;
        logic raw_more;
        logic fresh_any;
        logic new_rep;
        logic new_raw;
        logic new_fresh;
    } dp_status_t;

    function automatic logic [1:0] lead_extra(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c >= LEAD2_LO && c <= LEAD2_HI)
            r = 2'd1;
        else if (c >= LEAD_E0 && c <= LEAD3_HI)
            r = 2'd2;
        else if (c >= LEAD_F0 && c <= LEAD_F4)
            r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] lead_lo(input logic [7:0] c);
        logic [7:0] r;
        r = CONT_LO;
        if (c == LEAD_E0)
            r = E0_LO;
        else if (c == LEAD_F0)
            r = F0_LO;
        return r;
    endfunction

    function automatic logic [7:0] lead_hi(input logic [7:0] c);
        logic [7:0] r;
        r = CONT_HI;
        if (c == LEAD_ED)
            r = ED_HI;
        else if (c == LEAD_F4)
            r = F4_HI;
        return r;
    endfunction

    function automatic fresh_t ascii_kind(input logic [7:0] c);
        fresh_t r;
        unique case (c) inside
            CH_QUOTE, CH_BSLASH, C0_BS, C0_FF, C0_LF, C0_CR, C0_TAB: r = FR_ESC;
            default: r = (c < CTRL_LIMIT) ? FR_HEX : FR_LIT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            C0_BS:   r = CH_B;
            C0_FF:   r = CH_F;
            C0_LF:   r = CH_N;
            C0_CR:   r = CH_R;
            C0_TAB:  r = CH_T;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = CH_ZERO + {4'd0, n};
        else
            r = CH_LOWA + {4'd0, n} - 8'd10;
        return r;
    endfunction

    // "\ufffd"
    function automatic logic [7:0] repl_char(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_U;
            3'd5:    r = CH_D;
            default: r = CH_F;
        endcase
        return r;
    endfunction

    // "\u00" prefix of a control escape
    function automatic logic [7:0] uhex_char(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_U;
            default: r = CH_ZERO;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/jseu_datapath.sv
`default_nettype none

module jseu_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jseu_pkg::dp_cmd_t    cmd,
    output jseu_pkg::dp_status_t      status,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      out_last
);
    import jseu_pkg::*;

    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] needed_count_reg, needed_count_next;
    logic       held_wr;
    logic [1:0] held_wr_idx;

    logic [2:0] rep_left_reg;
    logic [2:0] raw_left_reg;
    logic [1:0] raw_idx_reg;
    logic [2:0] pos_reg;
    fresh_t     fresh_kind_reg;
    logic [7:0] cur_byte_reg;
    logic [7:0] esc_reg;
    logic       last_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    // plan for a new request
    logic       holding;
    logic       in_range;
    logic [7:0] range_lo;
    logic [7:0] range_hi;
    logic [1:0] extra;
    fresh_t     fr_kind;
    logic       fr_hold;
    logic [2:0] plan_rep;
    logic [2:0] plan_raw;
    fresh_t     plan_kind;

    logic       seg_end;
    logic [7:0] byte_next;

    always_comb
    begin
        holding  = (held_count_reg != 2'd0) && (needed_count_reg != 2'd0);
        range_lo = (held_count_reg == 2'd1) ? lead_lo(held_bytes_reg[0]) : CONT_LO;
        range_hi = (held_count_reg == 2'd1) ? lead_hi(held_bytes_reg[0]) : CONT_HI;
        in_range = (in_byte >= range_lo) && (in_byte <= range_hi);
        extra    = lead_extra(in_byte);

        fr_hold = 1'b0;
        if (!in_byte[7])
            fr_kind = ascii_kind(in_byte);
        else if (extra == 2'd0 || in_last)
            fr_kind = FR_REPL;
        else
        begin
            fr_kind = FR_NONE;
            fr_hold = 1'b1;
        end

        plan_rep          = 3'd0;
        plan_raw          = 3'd0;
        plan_kind         = FR_NONE;
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
        held_wr           = 1'b0;
        held_wr_idx       = 2'd0;

        if (!holding || !in_range)
        begin
            plan_rep  = holding ? {1'b0, held_count_reg} : 3'd0;
            plan_kind = fr_kind;
            if (fr_hold)
            begin
                held_wr           = 1'b1;
                held_count_next   = 2'd1;
                needed_count_next = extra;
            end
        end
        else if (needed_count_reg == 2'd1)
            plan_raw = {1'b0, held_count_reg} + 3'd1;
        else if (in_last)
            plan_rep = {1'b0, held_count_reg} + 3'd1;
        else if (held_count_reg != 2'd3)
        begin
            held_wr           = 1'b1;
            held_wr_idx       = held_count_reg;
            held_count_next   = held_count_reg + 2'd1;
            needed_count_next = needed_count_reg - 2'd1;
        end
    end

    always_comb
    begin
        seg_end   = 1'b1;
        byte_next = cur_byte_reg;
        case (cmd.seg)
            SEG_REPL:
            begin
                seg_end   = (pos_reg == SEQ_END);
                byte_next = repl_char(pos_reg);
            end
            SEG_RAW:
            begin
                if (raw_left_reg != 3'd1)
                begin
                    case (raw_idx_reg)
                        2'd0:    byte_next = held_bytes_reg[0];
                        2'd1:    byte_next = held_bytes_reg[1];
                        2'd2:    byte_next = held_bytes_reg[2];
                        default: byte_next = cur_byte_reg;
                    endcase
                end
            end
            SEG_FRESH:
            begin
                case (fresh_kind_reg)
                    FR_ESC:
                    begin
                        seg_end   = (pos_reg == 3'd1);
                        byte_next = (pos_reg == 3'd0) ? CH_BSLASH : esc_reg;
                    end
                    FR_HEX:
                    begin
                        seg_end = (pos_reg == SEQ_END);
                        if (pos_reg == SEQ_END)
                            byte_next = hex_char(cur_byte_reg[3:0]);
                        else if (pos_reg == 3'd4)
                            byte_next = hex_char(cur_byte_reg[7:4]);
                        else
                            byte_next = uhex_char(pos_reg);
                    end
                    FR_REPL:
                    begin
                        seg_end   = (pos_reg == SEQ_END);
                        byte_next = repl_char(pos_reg);
                    end
                    default:
                    begin
                        seg_end   = 1'b1;
                        byte_next = cur_byte_reg;
                    end
                endcase
            end
            default:
            begin
                seg_end   = 1'b1;
                byte_next = cur_byte_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && held_wr)
            held_bytes_reg[held_wr_idx] <= in_byte;
        if (cmd.load)
        begin
            cur_byte_reg <= in_byte;
            esc_reg      <= esc_char(in_byte);
            last_reg     <= in_last;
        end
        if (cmd.step)
        begin
            out_byte_reg <= byte_next;
            out_last_reg <= cmd.final_seg && seg_end && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg   <= 2'd0;
            needed_count_reg <= 2'd0;
            rep_left_reg     <= 3'd0;
            raw_left_reg     <= 3'd0;
            raw_idx_reg      <= 2'd0;
            pos_reg          <= 3'd0;
            fresh_kind_reg   <= FR_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.load)
            begin
                held_count_reg   <= held_count_next;
                needed_count_reg <= needed_count_next;
                rep_left_reg     <= plan_rep;
                raw_left_reg     <= plan_raw;
                raw_idx_reg      <= 2'd0;
                pos_reg          <= 3'd0;
                fresh_kind_reg   <= plan_kind;
            end
            else if (cmd.step)
            begin
                case (cmd.seg)
                    SEG_REPL:
                    begin
                        if (seg_end)
                        begin
                            pos_reg      <= 3'd0;
                            rep_left_reg <= rep_left_reg - 3'd1;
                        end
                        else
                            pos_reg <= pos_reg + 3'd1;
                    end
                    SEG_RAW:
                    begin
                        raw_left_reg <= raw_left_reg - 3'd1;
                        if (raw_left_reg != 3'd1)
                            raw_idx_reg <= raw_idx_reg + 2'd1;
                    end
                    SEG_FRESH:
                    begin
                        if (seg_end)
                        begin
                            pos_reg        <= 3'd0;
                            fresh_kind_reg <= FR_NONE;
                        end
                        else
                            pos_reg <= pos_reg + 3'd1;
                    end
                    default:
                    begin
                        pos_reg <= pos_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        status.slot_free = !out_valid_reg || !out_stall;
        status.seg_end   = seg_end;
        status.rep_more  = (rep_left_reg > 3'd1);
        status.raw_any   = (raw_left_reg != 3'd0);
        status.raw_more  = (raw_left_reg > 3'd1);
        status.fresh_any = (fresh_kind_reg != FR_NONE);
        status.new_rep   = (plan_rep != 3'd0);
        status.new_raw   = (plan_raw != 3'd0);
        status.new_fresh = (plan_kind != FR_NONE);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### hdl/jseu_ctrl.sv
`default_nettype none

module jseu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire jseu_pkg::dp_status_t status,
    output jseu_pkg::dp_cmd_t         cmd
);
    import jseu_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       item_done;

    // no segment follows the current one
    always_comb
    begin
        unique case (state_reg)
            CS_REPL:  item_done = !status.rep_more && !status.raw_any && !status.fresh_any;
            CS_RAW:   item_done = !status.raw_more && !status.fresh_any;
            CS_FRESH: item_done = 1'b1;
            default:  item_done = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.new_rep)
                        state_next = CS_REPL;
                    else if (status.new_raw)
                        state_next = CS_RAW;
                    else if (status.new_fresh)
                        state_next = CS_FRESH;
                end
            end
            CS_REPL:
            begin
                if (status.slot_free && status.seg_end && !status.rep_more)
                begin
                    if (status.raw_any)
                        state_next = CS_RAW;
                    else if (status.fresh_any)
                        state_next = CS_FRESH;
                    else
                        state_next = CS_IDLE;
                end
            end
            CS_RAW:
            begin
                if (status.slot_free && !status.raw_more)
                    state_next = status.fresh_any ? CS_FRESH : CS_IDLE;
            end
            CS_FRESH:
            begin
                if (status.slot_free && status.seg_end)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != CS_IDLE);
        cmd.load      = in_valid && (state_reg == CS_IDLE);
        cmd.step      = (state_reg != CS_IDLE) && status.slot_free;
        cmd.final_seg = item_done;
        unique case (state_reg)
            CS_RAW:   cmd.seg = SEG_RAW;
            CS_FRESH: cmd.seg = SEG_FRESH;
            default:  cmd.seg = SEG_REPL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### hdl/json_string_escape_utf8_check.sv
`default_nettype none

// channel | valid    | stall     | payload
// --------+----------+-----------+------------------
// input   | in_valid | in_stall  | in_byte, in_last
// output  | out_valid| out_stall | out_byte, out_last
//
// One request is taken per visit to idle; its escaped bytes (0 to 24 of them)
// then enter the output register one after another before the next is taken.
// in_stall is high from the cycle after a request is taken until its last byte
// enters the output register; it stays high while out_stall holds a full register.
// rst_n is asynchronous and clears the controller, counters and held-sequence
// state; the block is ready for a request right after reset.

module json_string_escape_utf8_check (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import jseu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    jseu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    jseu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

### tb/sv/json_escape_checker.sv
`timescale 1ns / 100ps

module json_escape_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    output int              errors,
    output int              pending
);
    import jseu_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } esc_char_t;

    esc_char_t  expected_chars[$];
    logic [7:0] seq_bytes [3];
    logic [1:0] seq_count;
    logic [1:0] seq_needed;
    string      hex_digits = "0123456789abcdef";

    task automatic push_char(input logic [7:0] c);
        esc_char_t item;
        item.ch = c;
        item.last = 1'b0;
        expected_chars.insert(expected_chars.size(), item);
    endtask

    task automatic push_replacement();
        push_char(CH_BSLASH);
        push_char(CH_U);
        push_char(CH_F);
        push_char(CH_F);
        push_char(CH_F);
        push_char(CH_D);
    endtask

    task automatic push_ascii(input logic [7:0] c);
        case (c) inside
            CH_QUOTE, CH_BSLASH:
            begin
                push_char(CH_BSLASH);
                push_char(c);
            end
            C0_BS:
            begin
                push_char(CH_BSLASH);
                push_char(CH_B);
            end
            C0_FF:
            begin
                push_char(CH_BSLASH);
                push_char(CH_F);
            end
            C0_LF:
            begin
                push_char(CH_BSLASH);
                push_char(CH_N);
            end
            C0_CR:
            begin
                push_char(CH_BSLASH);
                push_char(CH_R);
            end
            C0_TAB:
            begin
                push_char(CH_BSLASH);
                push_char(CH_T);
            end
            default:
            begin
                if (c < CTRL_LIMIT)
                begin
                    push_char(CH_BSLASH);
                    push_char(CH_U);
                    push_char(CH_ZERO);
                    push_char(CH_ZERO);
                    push_char(hex_digits[c[7:4]]);
                    push_char(hex_digits[c[3:0]]);
                end
                else
                begin
                    push_char(c);
                end
            end
        endcase
    endtask

    // continuation count of a lead byte and the allowed range of its first continuation
    task automatic lead_range(input logic [7:0] c, output logic [1:0] extra,
                              output logic [7:0] lo, output logic [7:0] hi);
        extra = 2'd0;
        lo = CONT_LO;
        hi = CONT_HI;
        if (c >= LEAD2_LO && c <= LEAD2_HI)
            extra = 2'd1;
        else if (c >= LEAD_E0 && c <= LEAD3_HI)
            extra = 2'd2;
        else if (c >= LEAD_F0 && c <= LEAD_F4)
            extra = 2'd3;
        if (c == LEAD_E0)
            lo = E0_LO;
        if (c == LEAD_F0)
            lo = F0_LO;
        if (c == LEAD_ED)
            hi = ED_HI;
        if (c == LEAD_F4)
            hi = F4_HI;
    endtask

    task automatic clear_sequence();
        seq_count = 2'd0;
        seq_needed = 2'd0;
    endtask

    task automatic start_fresh(input logic [7:0] c, input logic fin);
        logic [1:0] extra;
        logic [7:0] lo;
        logic [7:0] hi;
        if (c < CONT_LO)
        begin
            push_ascii(c);
        end
        else
        begin
            lead_range(c, extra, lo, hi);
            if (extra == 2'd0 || fin)
            begin
                push_replacement();
            end
            else
            begin
                seq_bytes[0] = c;
                seq_count = 2'd1;
                seq_needed = extra;
            end
        end
    endtask

    task automatic escape_request(input logic [7:0] c, input logic fin);
        int         first;
        logic [1:0] extra;
        logic [7:0] lo;
        logic [7:0] hi;
        first = expected_chars.size();
        if (seq_count == 2'd0 || seq_needed == 2'd0)
        begin
            clear_sequence();
            start_fresh(c, fin);
        end
        else
        begin
            lo = CONT_LO;
            hi = CONT_HI;
            if (seq_count == 2'd1)
                lead_range(seq_bytes[0], extra, lo, hi);
            if (c >= lo && c <= hi)
            begin
                if (seq_needed == 2'd1)
                begin
                    for (int i = 0; i < seq_count; i++)
                        push_char(seq_bytes[i]);
                    push_char(c);
                    clear_sequence();
                end
                else if (fin)
                begin
                    for (int i = 0; i <= seq_count; i++)
                        push_replacement();
                    clear_sequence();
                end
                else
                begin
                    seq_bytes[seq_count] = c;
                    seq_count = seq_count + 2'd1;
                    seq_needed = seq_needed - 2'd1;
                end
            end
            else
            begin
                for (int i = 0; i < seq_count; i++)
                    push_replacement();
                clear_sequence();
                start_fresh(c, fin);
            end
        end
        if (fin)
        begin
            clear_sequence();
            if (expected_chars.size() > first)
                expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        esc_char_t want;
        if (!rst_n)
        begin
            clear_sequence();
            expected_chars.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    $error("out_byte: expected nothing, got %h", out_byte);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        errors++;
                        $error("out_byte: expected %h, got %h", want.ch, out_byte);
                    end
                    if (out_last !== want.last)
                    begin
                        errors++;
                        $error("out_last: expected %b, got %b", want.last, out_last);
                    end
                end
            end
            if (in_valid && !in_stall)
                escape_request(in_byte, in_last);
            pending = expected_chars.size();
        end
    end

endmodule

### tb/sv/json_string_escape_utf8_check_test.sv
`timescale 1ns / 100ps

module json_string_escape_utf8_check_test;
    import jseu_pkg::*;

    typedef enum logic [3:0] {
        TK_TEXT,
        TK_CTRL,
        TK_ESCAPED,
        TK_UTF2,
        TK_UTF3,
        TK_UTF4,
        TK_CUT,
        TK_BAD_CONT,
        TK_STRAY,
        TK_ANY
    } token_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } stall_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    int         errors;
    int         pending;
    bit         hold_req = 1'b0;
    int         burst_left = 0;
    int         sent_count = 0;
    logic [7:0] text_bytes[$];

    // {last, byte}: escapes, control range, stray bytes, bad and cut-off sequences
    logic [8:0] directed_requests[$] = '{
        9'h000, 9'h01F, 9'h022, 9'h05C, 9'h008, 9'h00C, 9'h00A, 9'h00D, 9'h009,
        9'h020, 9'h17F,
        9'h0FF, 9'h080, 9'h0E0, 9'h080, 9'h141,
        9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
        9'h0F0, 9'h190,
        9'h1C2,
        9'h0ED, 9'h1A0
    };

    json_string_escape_utf8_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    json_escape_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        int          hold_n;
        mode = RX_FREE;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (hold_n = 0; hold_n < 400; hold_n++)
                    @(posedge clk);
            end
            else
            begin
                case (mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    // in_valid must already be low
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic token_t pick_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return TK_TEXT;
        if (r < 33)
            return TK_CTRL;
        if (r < 40)
            return TK_ESCAPED;
        if (r < 52)
            return TK_UTF2;
        if (r < 66)
            return TK_UTF3;
        if (r < 78)
            return TK_UTF4;
        if (r < 85)
            return TK_CUT;
        if (r < 92)
            return TK_BAD_CONT;
        if (r < 96)
            return TK_STRAY;
        return TK_ANY;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endtask

    task automatic add_token(input token_t kind);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        int         extra;
        int         conts;
        case (kind)
            TK_TEXT:
                add_byte(8'($urandom_range(8'h20, 8'h7F)));
            TK_CTRL:
                add_byte(8'($urandom_range(8'h00, 8'h1F)));
            TK_ESCAPED:
                add_byte($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
            TK_STRAY:
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                              : 8'($urandom_range(8'hF5, 8'hFF)));
            TK_ANY:
                add_byte(8'($urandom_range(8'h00, 8'hFF)));
            default:
            begin
                extra = (kind == TK_UTF2) ? 1 : (kind == TK_UTF3) ? 2 :
                        (kind == TK_UTF4) ? 3 : $urandom_range(1, 3);
                case (extra)
                    1:       lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
                    2:       lead = 8'($urandom_range(LEAD_E0, LEAD3_HI));
                    default: lead = 8'($urandom_range(LEAD_F0, LEAD_F4));
                endcase
                lo = (lead == LEAD_E0) ? E0_LO : (lead == LEAD_F0) ? F0_LO : CONT_LO;
                hi = (lead == LEAD_ED) ? ED_HI : (lead == LEAD_F4) ? F4_HI : CONT_HI;
                conts = (kind == TK_CUT || kind == TK_BAD_CONT) ? $urandom_range(0, extra - 1)
                                                                : extra;
                add_byte(lead);
                for (int k = 0; k < conts; k++)
                    add_byte(8'($urandom_range(k == 0 ? lo : CONT_LO,
                                               k == 0 ? hi : CONT_HI)));
                if (kind == TK_BAD_CONT)
                begin
                    if (conts == 0 && lo != CONT_LO)
                        add_byte(8'($urandom_range(CONT_LO, lo - 8'd1)));
                    else if (conts == 0 && hi != CONT_HI)
                        add_byte(8'($urandom_range(hi + 8'd1, CONT_HI)));
                    else if ($urandom_range(0, 1))
                        add_byte(8'($urandom_range(8'h00, 8'h7F)));
                    else
                        add_byte(8'($urandom_range(8'hC0, 8'hFF)));
                end
            end
        endcase
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_request(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    initial
    begin : stimulus
        int tokens;
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_requests[i])
            send_request(directed_requests[i][7:0], directed_requests[i][8]);

        while (sent_count < 450)
        begin
            // output side holds off while requests keep coming
            if (!hold_done && sent_count >= 150)
            begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (!pause_done && sent_count >= 300)
            begin
                pause_done = 1'b1;
                in_valid <= 1'b0;
                wait_drained();
                repeat ($urandom_range(3, 20)) @(posedge clk);
            end
            tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
            text_bytes.delete();
            repeat (tokens) add_token(pick_token());
            send_text();
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hdl/jseu_pkg.sv
hdl/jseu_datapath.sv
hdl/jseu_ctrl.sv
hdl/json_string_escape_utf8_check.sv
tb/sv/json_escape_checker.sv
tb/sv/json_string_escape_utf8_check_test.sv
